FILE: rtl/core/iru_pkg.sv
// ----------------------------------------------------------------------------
// Integer remainder unit package
// Shared types, element-type codes and widths for the remainder pipeline.
// ----------------------------------------------------------------------------
package iru_pkg;

	localparam int unsigned DataW  = 64;
	localparam int unsigned BitsPerStage = 4;
	localparam int unsigned NumDivStages = DataW / BitsPerStage;

	typedef enum logic [2:0] {
		OP_S8  = 3'd0,
		OP_U8  = 3'd1,
		OP_S16 = 3'd2,
		OP_U16 = 3'd3,
		OP_S32 = 3'd4,
		OP_U32 = 3'd5,
		OP_S64 = 3'd6,
		OP_U64 = 3'd7
	} opcode_t;

	typedef struct packed {
		logic [2:0]       opcode;
		logic [DataW-1:0] dividend;
		logic [DataW-1:0] divisor;
		logic             last_in;
	} in_word_t;

	typedef struct packed {
		logic [DataW-1:0] remainder;
		logic             last_out;
	} out_word_t;

	// Word carried between the divider stages.
	typedef struct packed {
		logic [DataW-1:0] quo;     // remaining dividend bits shifted up
		logic [DataW-1:0] rem;     // partial remainder
		logic [DataW-1:0] dvs;     // divisor magnitude
		logic [DataW-1:0] mask;    // element mask
		logic             neg;     // negate the final remainder
		logic             bypass;  // zero divisor: return dividend
		logic [DataW-1:0] raw;     // masked dividend for the bypass
		logic             last;
	} div_word_t;

	function automatic logic [DataW-1:0] elem_mask(input logic [2:0] op);
		logic [DataW-1:0] m;
		case (op[2:1])
			2'd0:    m = {{(DataW-8){1'b0}}, {8{1'b1}}};
			2'd1:    m = {{(DataW-16){1'b0}}, {16{1'b1}}};
			2'd2:    m = {{(DataW-32){1'b0}}, {32{1'b1}}};
			default: m = {DataW{1'b1}};
		endcase
		return m;
	endfunction

	function automatic logic [DataW-1:0] sign_bit(input logic [2:0] op);
		logic [DataW-1:0] s;
		case (op[2:1])
			2'd0:    s = {{(DataW-8){1'b0}}, 1'b1, 7'd0};
			2'd1:    s = {{(DataW-16){1'b0}}, 1'b1, 15'd0};
			2'd2:    s = {{(DataW-32){1'b0}}, 1'b1, 31'd0};
			default: s = {1'b1, {(DataW-1){1'b0}}};
		endcase
		return s;
	endfunction

endpackage

FILE: rtl/core/iru_prep.sv
// ----------------------------------------------------------------------------
// Remainder operand preparation
// Masks operands, takes magnitudes and registers the first divider word.
// ----------------------------------------------------------------------------
module iru_prep (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              vld,
	input  iru_pkg::in_word_t in_word,
	output logic              vld_s1,
	output iru_pkg::div_word_t word_s1
);
	import iru_pkg::*;

	logic [DataW-1:0] m, sb, a, b, am, bm;
	logic             sgn, a_neg, b_neg;

	always_comb begin
		m     = elem_mask(in_word.opcode);
		sb    = sign_bit(in_word.opcode);
		sgn   = ~in_word.opcode[0];
		a     = in_word.dividend & m;
		b     = in_word.divisor & m;
		a_neg = sgn & ((a & sb) != '0);
		b_neg = sgn & ((b & sb) != '0);
		am    = a_neg ? ((~a + 1'b1) & m) : a;
		bm    = b_neg ? ((~b + 1'b1) & m) : b;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= vld;
		end
	end

	always_ff @(posedge clk) begin
		word_s1.quo    <= am;
		word_s1.rem    <= '0;
		word_s1.dvs    <= bm;
		word_s1.mask   <= m;
		word_s1.neg    <= a_neg;
		word_s1.bypass <= (b == '0);
		word_s1.raw    <= a;
		word_s1.last   <= in_word.last_in;
	end

endmodule

FILE: rtl/core/iru_div_stage.sv
// ----------------------------------------------------------------------------
// Remainder divider stage
// Retires four dividend bits by restoring division and registers the word.
// ----------------------------------------------------------------------------
module iru_div_stage (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               vld,
	input  iru_pkg::div_word_t word,
	output logic               vld_s2,
	output iru_pkg::div_word_t word_s2
);
	import iru_pkg::*;

	div_word_t nxt;
	logic [DataW:0] trial;

	always_comb begin
		nxt = word;
		for (int i = 0; i < BitsPerStage; i++) begin
			trial = {nxt.rem, nxt.quo[DataW-1]} - {1'b0, nxt.dvs};
			if (!trial[DataW]) begin
				nxt.rem = trial[DataW-1:0];
			end else begin
				nxt.rem = {nxt.rem[DataW-2:0], nxt.quo[DataW-1]};
			end
			nxt.quo = {nxt.quo[DataW-2:0], 1'b0};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else begin
			vld_s2 <= vld;
		end
	end

	always_ff @(posedge clk) begin
		word_s2 <= nxt;
	end

endmodule

FILE: rtl/core/iru_finish.sv
// ----------------------------------------------------------------------------
// Remainder finish stage
// Applies the dividend sign, the zero-divisor bypass and the element mask.
// ----------------------------------------------------------------------------
module iru_finish (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                vld,
	input  iru_pkg::div_word_t  word,
	output logic                vld_s3,
	output iru_pkg::out_word_t  word_s3
);
	import iru_pkg::*;

	logic [DataW-1:0] r;

	always_comb begin
		if (word.bypass) begin
			r = word.raw;
		end else if (word.neg) begin
			r = (~word.rem + 1'b1) & word.mask;
		end else begin
			r = word.rem & word.mask;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else begin
			vld_s3 <= vld;
		end
	end

	always_ff @(posedge clk) begin
		word_s3.remainder <= r;
		word_s3.last_out  <= word.last;
	end

endmodule

FILE: rtl/core/integer_remainder_unit.sv
// ----------------------------------------------------------------------------
// Integer remainder unit
// Truncated-division remainder for 8/16/32/64-bit signed and unsigned words.
// ----------------------------------------------------------------------------
//
//  Channel   Signals                      Handshake
//  -------   --------------------------   ----------------------------------
//  input     start, busy, in_word         taken when start is high, busy low
//  output    done, out_word               valid for one cycle while done high
//
// The unit takes one word every cycle; busy is tied low because nothing in
// the pipeline ever waits. It has one preparation stage, 16 divider stages
// of four restoring-division bits each, and one finish stage. The divider
// chain of the 64-bit dividend sets the depth. Reset clears only the valid
// bits. The receiver cannot stall, so no result is ever held back.
//
module integer_remainder_unit (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  iru_pkg::in_word_t  in_word,
	output logic               done,
	output iru_pkg::out_word_t out_word
);
	import iru_pkg::*;

	logic      vld [NumDivStages+1];
	div_word_t wrd [NumDivStages+1];

	assign busy = 1'b0;

	// Operand masking and magnitude.
	iru_prep u_prep (
		.clk     (clk),
		.arst_n  (arst_n),
		.vld     (start & ~busy),
		.in_word (in_word),
		.vld_s1  (vld[0]),
		.word_s1 (wrd[0])
	);

	// Each stage retires four dividend bits; the remainder builds up in rem.
	for (genvar g = 0; g < NumDivStages; g++) begin : g_div
		iru_div_stage u_stage (
			.clk     (clk),
			.arst_n  (arst_n),
			.vld     (vld[g]),
			.word    (wrd[g]),
			.vld_s2  (vld[g+1]),
			.word_s2 (wrd[g+1])
		);
	end

	// Sign fix-up and zero-divisor bypass. The most negative value by minus
	// one falls out naturally: its magnitude divides evenly, giving zero.
	iru_finish u_finish (
		.clk     (clk),
		.arst_n  (arst_n),
		.vld     (vld[NumDivStages]),
		.word    (wrd[NumDivStages]),
		.vld_s3  (done),
		.word_s3 (out_word)
	);

	// An accepted word comes out exactly after the pipeline latency.
	assert property (@(posedge clk) disable iff (!arst_n)
		start |-> ##(NumDivStages+2) done)
		else $error("accepted word did not complete");

	// No result appears without a word accepted at the matching time.
	assert property (@(posedge clk) disable iff (!arst_n)
		!start |-> ##(NumDivStages+2) !done)
		else $error("result without accepted word");

	// The remainder never has bits above the element width.
	assert property (@(posedge clk) disable iff (!arst_n)
		vld[NumDivStages] |=>
		done && ((out_word.remainder & ~$past(wrd[NumDivStages].mask)) == '0))
		else $error("remainder has bits above the element width");

	// The remainder magnitude stays below a nonzero divisor magnitude.
	assert property (@(posedge clk) disable iff (!arst_n)
		vld[NumDivStages] && !wrd[NumDivStages].bypass |->
		wrd[NumDivStages].rem < wrd[NumDivStages].dvs)
		else $error("remainder not below divisor");

endmodule

FILE: verif/integer_remainder_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Integer remainder checker
// Watches the input and output words of the remainder unit, predicts each
// remainder and compares results in order against the predictions.
// ----------------------------------------------------------------------------
module integer_remainder_checker (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic               busy,
	input  iru_pkg::in_word_t  in_word,
	input  logic               done,
	input  iru_pkg::out_word_t out_word,
	output int                 fail_count,
	output int                 pending
);
	import iru_pkg::*;

	out_word_t expected_words[$];

	// Truncated remainder of the low element-width bits, zero-extended.
	function automatic logic [63:0] predict_remainder(input logic [2:0] op,
			input logic [63:0] a_raw, input logic [63:0] b_raw);
		logic [63:0] m;
		logic [63:0] sb;
		logic [63:0] a;
		logic [63:0] b;
		logic [63:0] am;
		logic [63:0] bm;
		logic [63:0] r;
		logic        a_neg;
		logic        b_neg;
		case (op[2:1])
			2'd0:    m = 64'hFF;
			2'd1:    m = 64'hFFFF;
			2'd2:    m = 64'hFFFF_FFFF;
			default: m = '1;
		endcase
		sb = (m >> 1) + 64'd1;
		a = a_raw & m;
		b = b_raw & m;
		if (b == 64'd0)
			return a;
		if (op[0])
			return a % b;
		a_neg = (a & sb) != 0;
		b_neg = (b & sb) != 0;
		am = a_neg ? ((~a + 64'd1) & m) : a;
		bm = b_neg ? ((~b + 64'd1) & m) : b;
		r = am % bm;
		if (a_neg)
			r = (~r + 64'd1) & m;
		return r & m;
	endfunction

	assign pending = expected_words.size();

	always @(posedge clk or negedge arst_n) begin
		out_word_t want;
		int        errs;
		errs = 0;
		if (!arst_n) begin
			fail_count <= 0;
		end else begin
			if (start && !busy) begin
				want.remainder = predict_remainder(in_word.opcode, in_word.dividend,
					in_word.divisor);
				want.last_out = in_word.last_in;
				expected_words.push_back(want);
			end
			if (done) begin
				if (expected_words.size() == 0) begin
					$display("%0t: unexpected result %h/%b", $time,
						out_word.remainder, out_word.last_out);
					errs++;
				end else begin
					want = expected_words.pop_front();
					if (want.remainder !== out_word.remainder) begin
						$display("%0t: remainder expected %h actual %h", $time,
							want.remainder, out_word.remainder);
						errs++;
					end
					if (want.last_out !== out_word.last_out) begin
						$display("%0t: last_out expected %b actual %b", $time,
							want.last_out, out_word.last_out);
						errs++;
					end
				end
			end
			fail_count <= fail_count + errs;
		end
	end
endmodule

FILE: verif/tb_integer_remainder_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Integer remainder unit testbench
// Drives directed corner words and random words of every element type into
// the remainder unit; a checker beside the unit predicts and compares.
// ----------------------------------------------------------------------------
module tb_integer_remainder_unit;
	import iru_pkg::*;

	// Drain the unit's pipeline with some margin.
	localparam int DrainCycles = 40;
	localparam int StallLimit  = 2000;
	localparam int RandomWords = 700;

	logic      clk;
	logic      arst_n;
	logic      start;
	logic      busy;
	logic      done;
	in_word_t  in_word;
	out_word_t out_word;
	int        fail_count;
	int        pending;
	int        idle_cycles;
	logic      timed_out;

	integer_remainder_unit dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.in_word(in_word), .done(done), .out_word(out_word)
	);

	integer_remainder_checker checker_i (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.in_word(in_word), .done(done), .out_word(out_word),
		.fail_count(fail_count), .pending(pending)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// The watchdog counts cycles in which neither a word nor a result moves.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idle_cycles <= 0;
		end else if ((start && !busy) || done) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		timed_out = 1'b0;
		@(posedge clk);
		wait (idle_cycles >= StallLimit);
		timed_out = 1'b1;
		$display("[FAIL] regression broken");
		$finish;
	end

	function automatic logic [63:0] rand64();
		return {$urandom(), $urandom()};
	endfunction

	// Operands are skewed toward values near the element sign bit and toward
	// small magnitudes so that the signed corner cases come up often.
	function automatic logic [63:0] pick_operand(input logic [2:0] op);
		logic [63:0] m;
		logic [63:0] sb;
		logic [63:0] v;
		case (op[2:1])
			2'd0:    m = 64'hFF;
			2'd1:    m = 64'hFFFF;
			2'd2:    m = 64'hFFFF_FFFF;
			default: m = '1;
		endcase
		sb = (m >> 1) + 64'd1;
		v = rand64();
		case ($urandom_range(0, 7))
			0: v = (v & ~m) | sb;
			1: v = (v & ~m) | m;
			2: v = (v & ~m);
			3: v = (v & ~m) | 64'($urandom_range(1, 9));
			4: v = (v & ~m) | ((-64'($urandom_range(1, 9))) & m);
			5: v = v & (m >> $urandom_range(0, 7));
			default: ;
		endcase
		return v;
	endfunction

	// Presents one word and holds it until the unit takes it.
	task automatic send_word(input opcode_t op, input logic [63:0] a,
			input logic [63:0] b, input logic last, input logic allow_gaps);
		if (allow_gaps) begin
			while ($urandom_range(0, 99) < 16) begin
				start <= 1'b0;
				@(posedge clk);
			end
		end
		start <= 1'b1;
		in_word.opcode <= op;
		in_word.dividend <= a;
		in_word.divisor <= b;
		in_word.last_in <= last;
		@(posedge clk);
		while (busy)
			@(posedge clk);
	endtask

	initial begin
		opcode_t     op;
		logic [63:0] m;
		logic [63:0] sb;
		arst_n = 1'b0;
		start = 1'b0;
		in_word = '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part: per element type, a zero divisor, the most negative
		// value by minus one, and extremes with garbage in the unused bits.
		for (int k = 0; k < 8; k++) begin
			op = opcode_t'(k);
			case (k / 2)
				0:       m = 64'hFF;
				1:       m = 64'hFFFF;
				2:       m = 64'hFFFF_FFFF;
				default: m = '1;
			endcase
			sb = (m >> 1) + 64'd1;
			send_word(op, 64'hA5A5_A5A5_A5A5_A5A5, ~m, 1'b0, 1'b0);
			send_word(op, sb | ~m, m, 1'b1, 1'b0);
			send_word(op, m, sb, k[0], 1'b0);
		end

		// A pause that lets every expected result arrive before going on.
		start <= 1'b0;
		@(posedge clk);
		wait (pending == 0);
		@(posedge clk);

		// Random part: the first stretch runs with no gaps at all.
		for (int i = 0; i < RandomWords; i++) begin
			op = opcode_t'($urandom_range(0, 7));
			send_word(op, pick_operand(op), pick_operand(op), 1'($urandom()),
				i >= 150);
		end
		start <= 1'b0;

		wait (pending == 0);
		repeat (DrainCycles) @(posedge clk);
		if (!timed_out) begin
			if (fail_count == 0)
				$display("[ OK ] regression clean");
			else
				$display("[FAIL] regression broken");
			$finish;
		end
	end
endmodule
